// ----- rtl/core/dps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// Shared field widths, entry and command types for the priority scheduler.
// ----------------------------------------------------------------------------
package dps_pkg;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 16;
    localparam int REM_W   = 8;
    localparam int PREQ_W  = 11;
    localparam int STEP_W  = 4;
    localparam int COUNT_OUT_W = 5;

    localparam logic [STEP_W-1:0] STEP_RESET = 4'd3;

    // Register index of priority_step in the configuration map
    localparam logic REG_STEP = 1'b0;

    // Opcodes of an incoming request
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
        logic [REM_W-1:0]         rem;
    } t_entry;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic   insert;
        logic   pop;
        t_entry key;
    } t_cmd;

endpackage

// ----- rtl/core/dps_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_cell
// One slot of the sorted ready chain: holds an entry, compares it with the
// broadcast key and takes data from its left or right neighbor.
// ----------------------------------------------------------------------------
module dps_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dps_pkg::t_cmd   i_cmd,
    input  dps_pkg::t_entry i_prev,
    input  logic            i_prev_go,
    input  dps_pkg::t_entry i_next,
    output dps_pkg::t_entry o_entry,
    output logic            o_go
);

    logic                              r_valid;
    logic [dps_pkg::ID_W-1:0]          r_id;
    logic signed [dps_pkg::PRIO_W-1:0] r_prio;
    logic [dps_pkg::REM_W-1:0]         r_rem;
    dps_pkg::t_entry                   n_entry;

    // Key belongs at or ahead of this slot
    assign o_go = !r_valid || (r_prio <= i_cmd.key.prio);

    assign o_entry = '{valid: r_valid, id: r_id, prio: r_prio, rem: r_rem};

    always_comb begin
        n_entry = o_entry;
        if (i_cmd.pop) begin
            n_entry = i_next;
        end else if (i_cmd.insert && o_go) begin
            if (i_prev_go) begin
                n_entry = i_prev;
            end else begin
                n_entry       = i_cmd.key;
                n_entry.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_entry.id;
        r_prio <= n_entry.prio;
        r_rem  <= n_entry.rem;
    end

endmodule

// ----- rtl/core/dynamic_priority_scheduler_unit.sv -----
`timescale 1ns / 1ps
// A result is registered in the output register when its request is accepted.
// An add makes an insert pass through the cell chain, a finishing tick a pop pass, an empty
// tick none, and a reinserting tick a pop pass then an insert pass that holds off requests.
// Reset (synchronous, active low) empties the table, drops any pending result and
// restores priority_step to 3. No clearing pass is needed.
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler_unit
// Ready table of processes kept sorted by priority in a chain of cells, with
// aging of the running process on every time slice.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [dps_pkg::ID_W-1:0]            i_process_id,
    input  logic [dps_pkg::REM_W-1:0]           i_need_time,
    input  logic signed [dps_pkg::PREQ_W-1:0]   i_priority_req,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_accepted,
    output logic                                o_ran_valid,
    output logic [dps_pkg::ID_W-1:0]            o_ran_id,
    output logic signed [dps_pkg::PRIO_W-1:0]   o_ran_priority,
    output logic [dps_pkg::REM_W-1:0]           o_ran_remaining,
    output logic                                o_finished,
    output logic [dps_pkg::COUNT_OUT_W-1:0]     o_ready_count,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer states
    localparam logic S_IDLE  = 1'b0;
    localparam logic S_REINS = 1'b1;

    logic                          r_state;
    logic                          n_state;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic [dps_pkg::STEP_W-1:0]    r_step;
    dps_pkg::t_entry               r_hold;
    dps_pkg::t_entry               n_hold;
    dps_pkg::t_cmd                 w_cmd;

    dps_pkg::t_entry               w_entry [TABLE_DEPTH];
    logic                          w_go    [TABLE_DEPTH];

    // result register
    logic                          r_out_valid;
    logic                          r_accepted;
    logic                          r_ran_valid;
    logic [dps_pkg::ID_W-1:0]      r_ran_id;
    logic signed [dps_pkg::PRIO_W-1:0] r_ran_priority;
    logic [dps_pkg::REM_W-1:0]     r_ran_remaining;
    logic                          r_finished;
    logic [CNT_W-1:0]              r_ready_count;

    logic                          w_take;
    logic                          w_add_ok;
    logic                          w_tick_run;
    logic                          w_full;
    logic                          w_empty;
    logic signed [dps_pkg::PRIO_W:0]   w_psub;
    logic signed [dps_pkg::PRIO_W-1:0] w_new_prio;
    logic [dps_pkg::REM_W-1:0]     w_new_rem;
    logic                          w_cfg_wr;

    // ------------------------------------------------------------------
    // Configuration: one register, priority_step, at byte address 0
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == dps_pkg::REG_STEP);
    assign prdata   = (paddr[2] == dps_pkg::REG_STEP) ? {28'd0, r_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dps_pkg::STEP_RESET;
        end else if (w_cfg_wr) begin
            r_step <= pwdata[dps_pkg::STEP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Request decode. The result of every request is known at accept time,
    // so it goes straight to the output register; only the reinsertion of
    // a ticked process needs a second pass through the chain.
    // ------------------------------------------------------------------
    assign w_full  = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_empty = (r_count == '0);

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_take     = i_in_valid && o_in_ready;

    assign w_add_ok   = (i_opcode == dps_pkg::OP_ADD) && (i_need_time != '0) && !w_full;
    assign w_tick_run = (i_opcode == dps_pkg::OP_TICK) && !w_empty;

    // Age the head entry: subtract the step, saturate at the signed minimum
    assign w_psub = {w_entry[0].prio[dps_pkg::PRIO_W-1], w_entry[0].prio}
                  - $signed({{(dps_pkg::PRIO_W + 1 - dps_pkg::STEP_W){1'b0}}, r_step});
    assign w_new_prio = (w_psub[dps_pkg::PRIO_W] != w_psub[dps_pkg::PRIO_W-1])
                      ? {1'b1, {(dps_pkg::PRIO_W-1){1'b0}}}
                      : w_psub[dps_pkg::PRIO_W-1:0];
    assign w_new_rem  = (w_entry[0].rem != '0) ? w_entry[0].rem - 1'b1 : '0;

    // Command broadcast to the chain
    always_comb begin
        w_cmd        = '0;
        w_cmd.key    = r_hold;
        if (r_state == S_REINS) begin
            w_cmd.insert = 1'b1;
        end else if (w_take && w_add_ok) begin
            w_cmd.insert    = 1'b1;
            w_cmd.key.valid = 1'b1;
            w_cmd.key.id    = i_process_id;
            w_cmd.key.prio  = dps_pkg::PRIO_W'(i_priority_req);
            w_cmd.key.rem   = i_need_time;
        end else if (w_take && w_tick_run) begin
            w_cmd.pop = 1'b1;
        end
    end

    // Sequencer: register the ticked process, then reinsert it if it has time left
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_hold  = r_hold;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && w_add_ok) begin
                    n_count = r_count + 1'b1;
                end else if (w_take && w_tick_run) begin
                    n_hold = '{valid: 1'b1, id: w_entry[0].id,
                               prio: w_new_prio, rem: w_new_rem};
                    if (w_new_rem == '0) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_state = S_REINS;
                    end
                end
            end
            S_REINS: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

    // ------------------------------------------------------------------
    // Result register: load on accept, drop when taken downstream
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_accepted      <= w_add_ok;
            r_ran_valid     <= w_tick_run;
            r_ran_id        <= w_tick_run ? w_entry[0].id : '0;
            r_ran_priority  <= w_tick_run ? w_new_prio : '0;
            r_ran_remaining <= w_tick_run ? w_new_rem : '0;
            r_finished      <= w_tick_run && (w_new_rem == '0);
            // count after this request; reinsertion leaves it unchanged
            r_ready_count   <= n_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_ran_valid     = r_ran_valid;
    assign o_ran_id        = r_ran_id;
    assign o_ran_priority  = r_ran_priority;
    assign o_ran_remaining = r_ran_remaining;
    assign o_finished      = r_finished;
    assign o_ready_count   = dps_pkg::COUNT_OUT_W'(r_ready_count);

    // ------------------------------------------------------------------
    // Sorted chain: slot 0 is the head
    // ------------------------------------------------------------------
    generate
        for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            dps_pkg::t_entry w_prev;
            dps_pkg::t_entry w_next;
            logic            w_prev_go;

            if (g == 0) begin : g_first
                assign w_prev    = '0;
                assign w_prev_go = 1'b0;
            end else begin : g_mid
                assign w_prev    = w_entry[g-1];
                assign w_prev_go = w_go[g-1];
            end

            if (g == TABLE_DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_entry[g+1];
            end

            dps_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (w_cmd),
                .i_prev    (w_prev),
                .i_prev_go (w_prev_go),
                .i_next    (w_next),
                .o_entry   (w_entry[g]),
                .o_go      (w_go[g])
            );
        end
    endgenerate

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add and tick requests into the priority scheduler, predicts every
// result from a local model of the sorted ready table, and compares each
// result field by field while both channels stall at random in all but the last test.
// ----------------------------------------------------------------------------
module testbench;

    import dps_pkg::*;

    localparam int TBL_DEPTH      = 16;
    localparam int RST_CYCLES     = 7;
    // Reinsertion may still be in the cell chain when its result leaves.
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [2:0] STEP_ADDR = {REG_STEP, 2'b00};

    localparam logic signed [PREQ_W-1:0] PREQ_MAX = 11'sh3FF;
    localparam logic signed [PREQ_W-1:0] PREQ_MIN = 11'sh400;

    // One expected result per request
    typedef struct packed {
        logic                     accepted;
        logic                     ran_valid;
        logic [ID_W-1:0]          ran_id;
        logic signed [PRIO_W-1:0] ran_priority;
        logic [REM_W-1:0]         ran_remaining;
        logic                     finished;
        logic [COUNT_OUT_W-1:0]   ready_count;
    } sched_result_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_opcode;
    logic [ID_W-1:0]            i_process_id;
    logic [REM_W-1:0]           i_need_time;
    logic signed [PREQ_W-1:0]   i_priority_req;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_accepted;
    logic                       o_ran_valid;
    logic [ID_W-1:0]            o_ran_id;
    logic signed [PRIO_W-1:0]   o_ran_priority;
    logic [REM_W-1:0]           o_ran_remaining;
    logic                       o_finished;
    logic [COUNT_OUT_W-1:0]     o_ready_count;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    // Local copy of the ready table, head at index 0
    logic [ID_W-1:0]            tbl_id   [TBL_DEPTH];
    logic signed [PRIO_W-1:0]   tbl_prio [TBL_DEPTH];
    logic [REM_W-1:0]           tbl_rem  [TBL_DEPTH];
    int                         tbl_count;
    logic [STEP_W-1:0]          cfg_step;

    sched_result_t              pending_results[$];
    int unsigned                fail_count;
    int unsigned                stall_cycles   = 0;
    int unsigned                send_idle_pct  = 34;
    int unsigned                recv_stall_pct = 54;

    dynamic_priority_scheduler_unit #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_process_id    (i_process_id),
        .i_need_time     (i_need_time),
        .i_priority_req  (i_priority_req),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_ran_valid     (o_ran_valid),
        .o_ran_id        (o_ran_id),
        .o_ran_priority  (o_ran_priority),
        .o_ran_remaining (o_ran_remaining),
        .o_finished      (o_finished),
        .o_ready_count   (o_ready_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stall the result channel at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Insert ahead of every entry of equal or lower priority.
    function automatic void insert_sorted(input logic [ID_W-1:0] pid,
                                          input logic signed [PRIO_W-1:0] prio,
                                          input logic [REM_W-1:0] rem);
        int pos;
        pos = 0;
        while (pos < tbl_count && tbl_prio[pos] > prio) pos++;
        for (int i = tbl_count; i > pos; i--) begin
            tbl_id[i]   = tbl_id[i-1];
            tbl_prio[i] = tbl_prio[i-1];
            tbl_rem[i]  = tbl_rem[i-1];
        end
        tbl_id[pos]   = pid;
        tbl_prio[pos] = prio;
        tbl_rem[pos]  = rem;
        tbl_count++;
    endfunction

    // Apply one request to the local table and return the result it causes.
    function automatic sched_result_t predict_schedule(input logic op,
                                                       input logic [ID_W-1:0] pid,
                                                       input logic [REM_W-1:0] need,
                                                       input logic signed [PREQ_W-1:0] preq);
        sched_result_t            res;
        logic [ID_W-1:0]          head_id;
        logic [REM_W-1:0]         rem_left;
        logic signed [PRIO_W-1:0] prio_ext;
        int                       aged;
        res = '0;
        if (op == OP_ADD) begin
            if (need != '0 && tbl_count < TBL_DEPTH) begin
                prio_ext = PRIO_W'(preq);
                insert_sorted(pid, prio_ext, need);
                res.accepted = 1'b1;
            end
        end else if (tbl_count > 0) begin
            head_id  = tbl_id[0];
            aged     = int'(tbl_prio[0]);
            rem_left = (tbl_rem[0] != '0) ? tbl_rem[0] - 1'b1 : '0;
            // Pop the head before deciding whether it goes back in.
            for (int i = 0; i < tbl_count - 1; i++) begin
                tbl_id[i]   = tbl_id[i+1];
                tbl_prio[i] = tbl_prio[i+1];
                tbl_rem[i]  = tbl_rem[i+1];
            end
            tbl_count--;
            aged = aged - int'(cfg_step);
            if (aged < -32768) aged = -32768;
            if (rem_left == '0) begin
                res.finished = 1'b1;
            end else begin
                insert_sorted(head_id, aged[PRIO_W-1:0], rem_left);
            end
            res.ran_valid     = 1'b1;
            res.ran_id        = head_id;
            res.ran_priority  = aged[PRIO_W-1:0];
            res.ran_remaining = rem_left;
        end
        res.ready_count = COUNT_OUT_W'(tbl_count);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------------

    task automatic check_field(input string field, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        sched_result_t exp_res;
        if (i_rst_n) begin
            // Any handshake on either channel counts as progress.
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    check_field("accepted", exp_res.accepted, o_accepted);
                    check_field("ran_valid", exp_res.ran_valid, o_ran_valid);
                    check_field("ran_id", exp_res.ran_id, o_ran_id);
                    check_field("ran_priority", exp_res.ran_priority, o_ran_priority);
                    check_field("ran_remaining", exp_res.ran_remaining, o_ran_remaining);
                    check_field("finished", exp_res.finished, o_finished);
                    check_field("ready_count", exp_res.ready_count, o_ready_count);
                end
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request and register access
    // ------------------------------------------------------------------------

    // Hold the request until accepted, then record its expected result.
    // Valid stays high on return so a back-to-back request can follow with valid still high.
    task automatic send_request(input logic op, input logic [ID_W-1:0] pid,
                                input logic [REM_W-1:0] need,
                                input logic signed [PREQ_W-1:0] preq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_process_id   <= pid;
        i_need_time    <= need;
        i_priority_req <= preq;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_schedule(op, pid, need, preq));
    endtask

    // Drop valid, wait for every result, then let the chain settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leave the bus idle after the write so the next access starts clean.
    task automatic write_step(input logic [STEP_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STEP_ADDR;
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_step = val;
        @(posedge i_clk);
    endtask

    task automatic check_step_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= STEP_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("priority_step", cfg_step, prdata[STEP_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random request: keep the table busy without letting it clog for good.
    task automatic send_random_request();
        logic                     op;
        logic [ID_W-1:0]          pid;
        logic [REM_W-1:0]         need;
        logic signed [PREQ_W-1:0] preq;
        int unsigned              roll;
        roll = $urandom_range(99);
        if (tbl_count == 0) begin
            op = (roll < 80) ? OP_ADD : OP_TICK;
        end else if (tbl_count >= TBL_DEPTH - 4) begin
            op = (roll < 30) ? OP_ADD : OP_TICK;
        end else begin
            op = (roll < 50) ? OP_ADD : OP_TICK;
        end
        pid  = ID_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 4) begin
            need = '0;
        end else if (roll < 5) begin
            need = REM_W'($urandom_range(255, 128));
        end else begin
            need = REM_W'($urandom_range(8, 1));
        end
        // Cluster priorities near zero to force ties.
        roll = $urandom_range(99);
        if (roll < 40) begin
            preq = PREQ_W'(int'($urandom_range(6)) - 3);
        end else if (roll < 50) begin
            preq = roll[0] ? PREQ_MAX : PREQ_MIN;
        end else begin
            preq = PREQ_W'($urandom);
        end
        send_request(op, pid, need, preq);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_step_reset_value();
        check_step_readback();
    endtask

    // Empty tick, zero time, ties on add and reinsert, full table, field extremes.
    task automatic test_directed_table();
        send_request(OP_TICK, 8'h00, 8'h00, '0);
        send_request(OP_ADD, 8'h00, 8'h00, '0);
        send_request(OP_ADD, 8'hFF, 8'h01, PREQ_MAX);
        send_request(OP_TICK, 8'h00, 8'h00, '0);
        send_request(OP_ADD, 8'h01, 8'hFF, PREQ_MIN);
        send_request(OP_ADD, 8'h02, 8'h02, 11'sd8);
        send_request(OP_ADD, 8'h03, 8'h03, 11'sd5);
        send_request(OP_ADD, 8'h04, 8'h01, 11'sd5);
        // Aged to 5, the runner goes back ahead of both equal entries.
        send_request(OP_TICK, 8'h00, 8'h00, '0);
        send_request(OP_TICK, 8'h00, 8'h00, '0);
        for (int k = 0; k < 13; k++) begin
            send_request(OP_ADD, ID_W'(16 + k), (k < 2) ? 8'hFF : REM_W'(1 + k % 3),
                         k[0] ? PREQ_W'(1023 - k) : PREQ_W'(k - 1024));
        end
        send_request(OP_ADD, 8'hAA, 8'h55, 11'sh2AA);
        send_request(OP_TICK, 8'h00, 8'h00, '0);
        send_request(OP_TICK, 8'h00, 8'h00, '0);
        wait_drained();
    endtask

    task automatic test_aging_max_step();
        write_step('1);
        check_step_readback();
        repeat (300) send_random_request();
        wait_drained();
    endtask

    task automatic test_aging_zero_step();
        send_idle_pct  = 54;
        recv_stall_pct = 34;
        write_step('0);
        check_step_readback();
        repeat (300) send_random_request();
        wait_drained();
    endtask

    task automatic test_aging_random_step();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_step(STEP_W'($urandom_range(14, 1)));
        check_step_readback();
        repeat (300) send_random_request();
        wait_drained();
    endtask

    initial begin
        // Drive every input but i_out_ready to a known value before the first edge.
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_opcode       <= OP_ADD;
        i_process_id   <= '0;
        i_need_time    <= '0;
        i_priority_req <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        cfg_step     = STEP_RESET;
        tbl_count    = 0;
        fail_count   = 0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_step_reset_value();
        test_directed_table();
        test_aging_max_step();
        test_aging_zero_step();
        test_aging_random_step();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
